// ----- hdl/pcrr_pkg.sv -----
// ---------------------------------------------------------------------------
// pcrr_pkg
// Shared types and constants for the per-class round-robin id pool.
// ---------------------------------------------------------------------------
`default_nettype none

package pcrr_pkg;

  localparam int NUM_CLASSES = 256;
  localparam int POOL_DEPTH  = 8;
  localparam int ID_W        = 64;
  localparam int CLS_IN_W    = 16;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int SLOT_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
  localparam int ENT_AW      = CLS_W + SLOT_W;
  localparam int ST_W        = 3;

  localparam logic [ID_W-1:0] INVALID_ID = '1;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic REG_USE_FALLBACK = 1'b0;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADCLASS = 3'd3,
    ST_TAKEN    = 3'd4,
    ST_NONE     = 3'd5,
    ST_INVALID  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_SCAN,
    S_TK_CHK,
    S_TK_WAIT,
    S_TK_DATA,
    S_OUT
  } state_t;

  // per-class bookkeeping word
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] slot;
  } meta_t;

  typedef struct packed {
    logic capture;
    logic set_bad;
    logic set_none;
    logic add_commit;
    logic use_zero_set;
    logic take_start;
    logic take_finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic in_range;
    logic use_zero;
    logic meta_nz;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- hdl/pcrr_ctrl.sv -----
// ---------------------------------------------------------------------------
// pcrr_ctrl
// Sequencer for add and take items; drives datapath commands.
// ---------------------------------------------------------------------------
`default_nettype none

module pcrr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           use_fallback,
  input  wire pcrr_pkg::stat_t st,
  output pcrr_pkg::cmd_t      cmd
);

  pcrr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcrr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcrr_pkg::S_IDLE: begin
        if (in_valid) state_next = pcrr_pkg::S_DECODE;
      end
      pcrr_pkg::S_DECODE: begin
        if (st.mode == pcrr_pkg::MODE_ADD) begin
          state_next = st.in_range ? pcrr_pkg::S_ADD_SCAN : pcrr_pkg::S_OUT;
        end else begin
          state_next = (st.in_range || use_fallback) ? pcrr_pkg::S_TK_CHK : pcrr_pkg::S_OUT;
        end
      end
      pcrr_pkg::S_ADD_SCAN: begin
        if (st.scan_done) state_next = pcrr_pkg::S_OUT;
      end
      pcrr_pkg::S_TK_CHK: begin
        if (st.meta_nz) begin
          state_next = pcrr_pkg::S_TK_DATA;
        end else if (use_fallback && !st.use_zero) begin
          state_next = pcrr_pkg::S_TK_WAIT;
        end else begin
          state_next = pcrr_pkg::S_OUT;
        end
      end
      pcrr_pkg::S_TK_WAIT: state_next = pcrr_pkg::S_TK_CHK;
      pcrr_pkg::S_TK_DATA: state_next = pcrr_pkg::S_OUT;
      pcrr_pkg::S_OUT: begin
        if (st.out_free) state_next = pcrr_pkg::S_IDLE;
      end
      default: state_next = pcrr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      pcrr_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      pcrr_pkg::S_DECODE: begin
        if (st.mode == pcrr_pkg::MODE_ADD) begin
          cmd.set_bad = !st.in_range;
        end else begin
          cmd.set_none = !(st.in_range || use_fallback);
        end
      end
      pcrr_pkg::S_ADD_SCAN: begin
        cmd.add_commit = st.scan_done;
      end
      pcrr_pkg::S_TK_CHK: begin
        if (st.meta_nz) begin
          cmd.take_start = 1'b1;
        end else if (use_fallback && !st.use_zero) begin
          cmd.use_zero_set = 1'b1;
        end else begin
          cmd.set_none = 1'b1;
        end
      end
      pcrr_pkg::S_TK_WAIT: ;
      pcrr_pkg::S_TK_DATA: cmd.take_finish = 1'b1;
      pcrr_pkg::S_OUT:     cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/pcrr_datapath.sv -----
// ---------------------------------------------------------------------------
// pcrr_datapath
// Pool memory, per-class count/slot memory, duplicate scan, result regs.
// ---------------------------------------------------------------------------
`default_nettype none

module pcrr_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire pcrr_pkg::cmd_t                         cmd,
  output pcrr_pkg::stat_t                             st,
  input  wire logic                                   mode,
  input  wire logic signed [pcrr_pkg::CLS_IN_W-1:0]   class_index,
  input  wire logic        [pcrr_pkg::ID_W-1:0]       resource_id,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [pcrr_pkg::ST_W-1:0]       status,
  output logic             [pcrr_pkg::ID_W-1:0]       taken_id
);

  localparam int CLS_W  = pcrr_pkg::CLS_W;
  localparam int SLOT_W = pcrr_pkg::SLOT_W;
  localparam int CNT_W  = pcrr_pkg::CNT_W;
  localparam int ID_W   = pcrr_pkg::ID_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(pcrr_pkg::POOL_DEPTH);

  // captured item
  logic             mode_r;
  logic [CLS_W-1:0] cls_r;
  logic             in_range_r;
  logic [ID_W-1:0]  rid_r;
  logic             use_zero;

  // memories
  logic [ID_W-1:0]       pool_mem [pcrr_pkg::NUM_CLASSES*pcrr_pkg::POOL_DEPTH];
  pcrr_pkg::meta_t       meta_mem [pcrr_pkg::NUM_CLASSES];
  logic [pcrr_pkg::NUM_CLASSES-1:0] meta_vld;

  logic [CLS_W-1:0]           meta_addr;
  pcrr_pkg::meta_t            meta_q;
  logic                       meta_vq;
  logic [pcrr_pkg::ENT_AW-1:0] ent_addr;
  logic [ID_W-1:0]            ent_q;

  // scan state
  logic [CNT_W-1:0] idx;
  logic             cmp_pend;
  logic             dup;
  logic             scan_hold;

  // result
  pcrr_pkg::status_t res_status;
  logic [ID_W-1:0]   res_id;

  logic [CNT_W-1:0]  cnt_eff;
  logic [SLOT_W-1:0] slot_raw;
  logic [SLOT_W-1:0] slot_eff;
  logic [CNT_W-1:0]  slot_inc;
  logic [SLOT_W-1:0] slot_new;
  logic              in_range_in;
  logic              full;
  pcrr_pkg::meta_t   meta_wr;

  assign in_range_in = (class_index[pcrr_pkg::CLS_IN_W-1:CLS_W] == '0);

  assign meta_addr = use_zero ? '0 : cls_r;
  assign cnt_eff   = meta_vq ? meta_q.cnt : '0;
  assign slot_raw  = meta_vq ? meta_q.slot : '0;
  assign slot_eff  = ({1'b0, slot_raw} >= cnt_eff) ? '0 : slot_raw;
  assign slot_inc  = {1'b0, slot_eff} + CNT_W'(1);
  assign slot_new  = (slot_inc >= cnt_eff) ? '0 : slot_inc[SLOT_W-1:0];
  assign full      = (cnt_eff >= FULL_CNT);

  // add scans the class pool, take reads the chosen slot
  assign ent_addr = (mode_r == pcrr_pkg::MODE_ADD) ? {cls_r, idx[SLOT_W-1:0]}
                                                   : {meta_addr, slot_eff};

  always_comb begin
    meta_wr = meta_q;
    if (cmd.take_start) begin
      meta_wr.cnt  = cnt_eff;
      meta_wr.slot = slot_new;
    end else begin
      meta_wr.cnt  = cnt_eff + CNT_W'(1);
      meta_wr.slot = slot_raw;
    end
  end

  always_ff @(posedge clk) begin
    meta_q <= meta_mem[meta_addr];
    ent_q  <= pool_mem[ent_addr];
    if (cmd.add_commit && !dup && !full) begin
      pool_mem[{cls_r, cnt_eff[SLOT_W-1:0]}] <= rid_r;
      meta_mem[cls_r] <= meta_wr;
    end else if (cmd.take_start) begin
      meta_mem[meta_addr] <= meta_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_vld <= '0;
      meta_vq  <= 1'b0;
    end else begin
      meta_vq <= meta_vld[meta_addr];
      if (cmd.add_commit && !dup && !full) meta_vld[cls_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_zero <= 1'b0;
    end else if (cmd.capture) begin
      use_zero <= !in_range_in;
    end else if (cmd.use_zero_set) begin
      use_zero <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r     <= mode;
      cls_r      <= class_index[CLS_W-1:0];
      in_range_r <= in_range_in;
      rid_r      <= resource_id;
    end
  end

  // the count of the new class reaches meta_q only after cls_r and then meta_q are registered
  always_ff @(posedge clk) begin
    scan_hold <= cmd.capture;
  end

  // one read issued per cycle, compare lands in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.capture || scan_hold) begin
      idx      <= '0;
      cmp_pend <= 1'b0;
      dup      <= 1'b0;
    end else begin
      if (cmp_pend && (ent_q == rid_r)) dup <= 1'b1;
      if (idx < cnt_eff) begin
        idx      <= idx + CNT_W'(1);
        cmp_pend <= 1'b1;
      end else begin
        cmp_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_bad) begin
      res_status <= pcrr_pkg::ST_BADCLASS;
      res_id     <= '0;
    end else if (cmd.set_none) begin
      res_status <= pcrr_pkg::ST_NONE;
      res_id     <= '0;
    end else if (cmd.add_commit) begin
      res_id <= '0;
      if (dup) begin
        res_status <= pcrr_pkg::ST_DUP;
      end else if (full) begin
        res_status <= pcrr_pkg::ST_FULL;
      end else begin
        res_status <= pcrr_pkg::ST_ADDED;
      end
    end else if (cmd.take_finish) begin
      if (ent_q == pcrr_pkg::INVALID_ID) begin
        res_status <= pcrr_pkg::ST_INVALID;
        res_id     <= '0;
      end else begin
        res_status <= pcrr_pkg::ST_TAKEN;
        res_id     <= ent_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status   <= res_status;
      taken_id <= res_id;
    end
  end

  always_comb begin
    st.mode      = mode_r;
    st.in_range  = in_range_r;
    st.use_zero  = use_zero;
    st.meta_nz   = (cnt_eff != '0);
    st.scan_done = (idx >= cnt_eff) && !cmp_pend;
    st.out_free  = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ----- hdl/per_class_round_robin_pool.sv -----
// ---------------------------------------------------------------------------
// per_class_round_robin_pool
// Per-class pools of 64-bit ids with duplicate-checked add and round-robin
// take, with optional fallback to the class 0 pool.
//
// input channel: in_valid/in_stall carries one word {mode, class_index,
//   resource_id}; mode 0 adds the id to its class, mode 1 takes the next id
// output channel: out_valid/out_stall carries {status, taken_id}, one word
//   per input word, in order
// apb port: register 0 (address 0) is use_fallback, bit 0
// one word is worked at a time; a bad class goes from decode straight to
//   output unless a take falls back to class 0, and an add runs a duplicate
//   scan that reads the class pool one entry per cycle from a single port
// the result goes to an output register; a stalled result holds, a finished
//   result waits until that register is free, and the next word is taken
//   once the previous result has moved into it
// reset clears the class counts and round-robin slots at once (per-class
//   valid bits), sets use_fallback, and empties the output register
// ---------------------------------------------------------------------------
`default_nettype none

module per_class_round_robin_pool (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 mode,
  input  wire logic signed [pcrr_pkg::CLS_IN_W-1:0] class_index,
  input  wire logic        [pcrr_pkg::ID_W-1:0]     resource_id,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic             [pcrr_pkg::ST_W-1:0]     status,
  output logic             [pcrr_pkg::ID_W-1:0]     taken_id,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic        [2:0]                    paddr,
  input  wire logic        [31:0]                   pwdata,
  output logic             [31:0]                   prdata,
  output logic                                      pready
);

  logic            use_fallback;
  logic            reg_sel;
  pcrr_pkg::cmd_t  cmd;
  pcrr_pkg::stat_t st;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == pcrr_pkg::REG_USE_FALLBACK);

  always_ff @(posedge clk) begin
    if (rst) begin
      use_fallback <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      use_fallback <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {31'b0, use_fallback} : '0;

  pcrr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .use_fallback (use_fallback),
    .st           (st),
    .cmd          (cmd)
  );

  pcrr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (mode),
    .class_index (class_index),
    .resource_id (resource_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .taken_id    (taken_id)
  );

endmodule

`default_nettype wire
